// File: rtl/core/prbfa_pkg.sv
// ----------------------------------------------------------------------------
// Page run allocator package
// Field widths, status and action codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package prbfa_pkg;

    localparam int ACTION_W = 1;
    localparam int SIZE_W   = 27;
    localparam int OFFSET_W = 26;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 11;

    localparam int MAX_PAGES_DEF  = 1024;
    localparam int MAX_RUNS_DEF   = 64;
    localparam int PAGE_SHIFT_DEF = 16;
    localparam int NUM_PAGES_RST  = 1024;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STS_OK           = 4'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_SIZE     = 4'd1;
    localparam logic [STATUS_W-1:0] STS_NO_FIT       = 4'd2;
    localparam logic [STATUS_W-1:0] STS_OUT_OF_RANGE = 4'd3;
    localparam logic [STATUS_W-1:0] STS_MISALIGNED   = 4'd4;
    localparam logic [STATUS_W-1:0] STS_BEYOND_END   = 4'd5;
    localparam logic [STATUS_W-1:0] STS_OVERLAP_PREV = 4'd6;
    localparam logic [STATUS_W-1:0] STS_OVERLAP_NEXT = 4'd7;
    localparam logic [STATUS_W-1:0] STS_TABLE_FULL   = 4'd8;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic check;
        logic scan_start;
        logic decide;
        logic write_ent;
        logic stats_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic chk_fail;
        logic iter_done;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/page_run_best_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// Page run best-fit allocator core
// Page-granular arena allocator over a sorted table of free runs.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the s_ channel carries an action (allocate
// or free), a byte size and, for a free, a byte offset. Each request yields
// exactly one result transaction on the m_ channel with a status code, the
// granted offset and size for a successful allocate, and the total free pages
// and the longest free run after the operation.
// Timing: one request is in work at a time. A request that fails its checks
// skips the scan and update and goes straight to the statistics scan. The
// next request is accepted from the cycle in which the result is registered.
// The run table is a single memory with one read and one write port: the
// best-fit or position scan, the shift on insert or removal, and the
// statistics scan each walk it one entry per cycle.
// The result sits in an output register; a new request is accepted while a
// stalled result still waits, and work stops only when a second result is
// ready before the first has been taken.
// Reset: after aresetn the arena holds MAX_PAGES (at most 1024) pages as a
// single free run; that entry is written in the init state before s_ready rises.
// Writing the arena size through cfg_we/cfg_wdata, while idle, resets the
// table to one run of that many pages (saturated to 1 .. MAX_PAGES).
// ----------------------------------------------------------------------------
module page_run_best_fit_allocator_core #(
    parameter int MAX_PAGES  = prbfa_pkg::MAX_PAGES_DEF,
    parameter int MAX_RUNS   = prbfa_pkg::MAX_RUNS_DEF,
    parameter int PAGE_SHIFT = prbfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [prbfa_pkg::COUNT_W-1:0]       cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [prbfa_pkg::ACTION_W-1:0]      s_action,
    input  logic [prbfa_pkg::SIZE_W-1:0]        s_size_bytes,
    input  logic [prbfa_pkg::OFFSET_W-1:0]      s_byte_offset,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [prbfa_pkg::STATUS_W-1:0]      m_status,
    output logic [prbfa_pkg::OFFSET_W-1:0]      m_grant_offset,
    output logic [prbfa_pkg::SIZE_W-1:0]        m_granted_bytes,
    output logic [prbfa_pkg::COUNT_W-1:0]       m_free_pages_total,
    output logic [prbfa_pkg::COUNT_W-1:0]       m_largest_free_run
);

    // Command and status bundles between the sequencer and the datapath.
    prbfa_pkg::cmd_t cmd;
    prbfa_pkg::sts_t sts;

    // The controller only steps through phases; all table state, checks and
    // the result register live in the datapath.
    prbfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    prbfa_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .MAX_RUNS   (MAX_RUNS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_action           (s_action),
        .s_size_bytes       (s_size_bytes),
        .s_byte_offset      (s_byte_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_grant_offset     (m_grant_offset),
        .m_granted_bytes    (m_granted_bytes),
        .m_free_pages_total (m_free_pages_total),
        .m_largest_free_run (m_largest_free_run)
    );

endmodule

// File: rtl/core/prbfa_ctrl.sv
// ----------------------------------------------------------------------------
// Page run allocator controller
// Sequences check, table scan, update, statistics scan and result hand-off.
// ----------------------------------------------------------------------------
module prbfa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  prbfa_pkg::sts_t sts,
    output prbfa_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_DECIDE = 4'd4;
    localparam logic [3:0] ST_MOVE   = 4'd5;
    localparam logic [3:0] ST_WRITE  = 4'd6;
    localparam logic [3:0] ST_STATS  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.chk_fail) begin
                    cmd.stats_start = 1'b1;
                    state_next      = ST_STATS;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.iter_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_MOVE;
            end
            ST_MOVE: begin
                if (sts.iter_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_ent   = 1'b1;
                cmd.stats_start = 1'b1;
                state_next      = ST_STATS;
            end
            ST_STATS: begin
                if (sts.iter_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// File: rtl/core/prbfa_dp.sv
// ----------------------------------------------------------------------------
// Page run allocator datapath
// Run table memory, request checks, a shared read iterator for scans and
// table shifts, the update decision and the result register.
// ----------------------------------------------------------------------------
module prbfa_dp #(
    parameter int MAX_PAGES  = prbfa_pkg::MAX_PAGES_DEF,
    parameter int MAX_RUNS   = prbfa_pkg::MAX_RUNS_DEF,
    parameter int PAGE_SHIFT = prbfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  prbfa_pkg::cmd_t                     cmd,
    output prbfa_pkg::sts_t                     sts,
    input  logic                                cfg_we,
    input  logic [prbfa_pkg::COUNT_W-1:0]       cfg_wdata,
    input  logic [prbfa_pkg::ACTION_W-1:0]      s_action,
    input  logic [prbfa_pkg::SIZE_W-1:0]        s_size_bytes,
    input  logic [prbfa_pkg::OFFSET_W-1:0]      s_byte_offset,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [prbfa_pkg::STATUS_W-1:0]      m_status,
    output logic [prbfa_pkg::OFFSET_W-1:0]      m_grant_offset,
    output logic [prbfa_pkg::SIZE_W-1:0]        m_granted_bytes,
    output logic [prbfa_pkg::COUNT_W-1:0]       m_free_pages_total,
    output logic [prbfa_pkg::COUNT_W-1:0]       m_largest_free_run
);

    localparam int SW  = prbfa_pkg::SIZE_W;
    localparam int OW  = prbfa_pkg::OFFSET_W;
    localparam int PGW = $clog2(MAX_PAGES);
    localparam int CW  = $clog2(MAX_PAGES + 1);
    localparam int IW  = $clog2(MAX_RUNS);
    localparam int HW  = $clog2(MAX_RUNS + 1);
    localparam int NW  = SW - PAGE_SHIFT + 1;
    localparam int FW  = OW - PAGE_SHIFT;
    localparam int EW  = PGW + CW;
    localparam int WW  = 32;

    // Run table: first page in the upper bits, page count in the lower bits.
    logic [EW-1:0] mem [MAX_RUNS];
    logic [EW-1:0] rd_data_reg;

    logic [CW-1:0] np_reg;
    logic [HW-1:0] held_reg;

    logic [prbfa_pkg::ACTION_W-1:0] act_reg;
    logic [SW-1:0]  size_reg;
    logic [OW-1:0]  off_reg;
    logic [CW-1:0]  need_reg;
    logic [PGW-1:0] fp_reg;
    logic [prbfa_pkg::STATUS_W-1:0] status_reg;
    logic [OW-1:0]  grant_reg;
    logic [SW-1:0]  granted_reg;

    logic [HW-1:0] it_cnt_reg;
    logic [HW-1:0] it_addr_reg;
    logic          it_inc_reg;
    logic          it_move_reg;
    logic          it_stats_reg;
    logic          pend_reg;
    logic [HW-1:0] pend_addr_reg;

    logic           found_reg;
    logic [IW-1:0]  best_idx_reg;
    logic [PGW-1:0] best_first_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic           hp_reg;
    logic [PGW-1:0] prev_first_reg;
    logic [CW-1:0]  prev_cnt_reg;
    logic           hn_reg;
    logic [PGW-1:0] next_first_reg;
    logic [CW-1:0]  next_cnt_reg;
    logic [HW-1:0]  ins_reg;

    logic [CW-1:0] tot_reg;
    logic [CW-1:0] lg_reg;

    logic          wr_req_reg;
    logic [IW-1:0] wr_addr_reg;
    logic [EW-1:0] wr_data_reg;

    logic                           m_valid_reg;
    logic [prbfa_pkg::STATUS_W-1:0] m_status_reg;
    logic [OW-1:0]                  m_grant_reg;
    logic [SW-1:0]                  m_granted_reg;
    logic [prbfa_pkg::COUNT_W-1:0]  m_tot_reg;
    logic [prbfa_pkg::COUNT_W-1:0]  m_lg_reg;

    // Request checks.
    logic [SW:0]   size_sum;
    logic [NW-1:0] need_w;
    logic [FW-1:0] fpage_w;
    logic          sz_zero, too_big, oor, mis, beyond;
    logic [prbfa_pkg::STATUS_W-1:0] chk_status;

    assign size_sum = {1'b0, size_reg}
                    + {{(SW + 1 - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    assign need_w   = size_sum[SW:PAGE_SHIFT];
    assign fpage_w  = off_reg[OW-1:PAGE_SHIFT];
    assign sz_zero  = (size_reg == '0);
    assign too_big  = WW'(need_w) > WW'(np_reg);
    assign oor      = WW'(fpage_w) >= WW'(np_reg);
    assign mis      = (off_reg[PAGE_SHIFT-1:0] != '0);
    assign beyond   = WW'(need_w) > (WW'(np_reg) - WW'(fpage_w));

    always_comb begin
        chk_status = prbfa_pkg::STS_OK;
        if (act_reg == prbfa_pkg::ACT_ALLOC) begin
            if (sz_zero || too_big) begin
                chk_status = prbfa_pkg::STS_BAD_SIZE;
            end
        end else begin
            if (sz_zero) begin
                chk_status = prbfa_pkg::STS_BAD_SIZE;
            end else if (oor) begin
                chk_status = prbfa_pkg::STS_OUT_OF_RANGE;
            end else if (mis) begin
                chk_status = prbfa_pkg::STS_MISALIGNED;
            end else if (too_big) begin
                chk_status = prbfa_pkg::STS_BAD_SIZE;
            end else if (beyond) begin
                chk_status = prbfa_pkg::STS_BEYOND_END;
            end
        end
    end

    // Configuration value saturated to the arena limits.
    logic [CW-1:0] cfg_pages;
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_pages = CW'(1);
        end else if (WW'(cfg_wdata) > WW'(MAX_PAGES)) begin
            cfg_pages = CW'(MAX_PAGES);
        end else begin
            cfg_pages = CW'(cfg_wdata);
        end
    end

    // Entry under the iterator.
    logic [PGW-1:0] e_first;
    logic [CW-1:0]  e_cnt;
    assign e_first = rd_data_reg[EW-1:CW];
    assign e_cnt   = rd_data_reg[CW-1:0];

    // Free decision terms.
    logic [CW:0]   prev_end;
    logic [CW:0]   new_end;
    logic          ov_p, ov_n, jp, jn;
    logic [IW-1:0] ins_idx;
    logic [IW-1:0] ins_m1;
    assign prev_end = (CW + 1)'(prev_first_reg) + (CW + 1)'(prev_cnt_reg);
    assign new_end  = (CW + 1)'(fp_reg) + (CW + 1)'(need_reg);
    assign ov_p     = hp_reg && (prev_end > (CW + 1)'(fp_reg));
    assign ov_n     = hn_reg && (new_end > (CW + 1)'(next_first_reg));
    assign jp       = hp_reg && (prev_end == (CW + 1)'(fp_reg));
    assign jn       = hn_reg && (new_end == (CW + 1)'(next_first_reg));
    assign ins_idx  = ins_reg[IW-1:0];
    assign ins_m1   = ins_idx - IW'(1);

    // Memory write selection.
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [HW-1:0] mv_dst;

    assign mv_dst = it_inc_reg ? (pend_addr_reg - HW'(1)) : (pend_addr_reg + HW'(1));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = {{PGW{1'b0}}, np_reg};
        if (cfg_we) begin
            mem_we    = 1'b1;
            mem_wdata = {{PGW{1'b0}}, cfg_pages};
        end else if (cmd.init_wr) begin
            mem_we = 1'b1;
        end else if (pend_reg && it_move_reg) begin
            mem_we    = 1'b1;
            mem_waddr = mv_dst[IW-1:0];
            mem_wdata = rd_data_reg;
        end else if (cmd.write_ent && wr_req_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (it_cnt_reg != '0) begin
            rd_data_reg <= mem[it_addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            np_reg      <= CW'(prbfa_pkg::NUM_PAGES_RST > MAX_PAGES ?
                                MAX_PAGES : prbfa_pkg::NUM_PAGES_RST);
            held_reg    <= HW'(1);
            it_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                np_reg   <= cfg_pages;
                held_reg <= HW'(1);
            end
            if (cmd.init_wr) begin
                held_reg <= HW'(1);
            end

            if (cmd.load) begin
                act_reg  <= s_action;
                size_reg <= s_size_bytes;
                off_reg  <= s_byte_offset;
            end

            if (cmd.check) begin
                status_reg  <= chk_status;
                need_reg    <= CW'(need_w);
                fp_reg      <= PGW'(fpage_w);
                grant_reg   <= '0;
                granted_reg <= '0;
            end

            // Iterator: one read per cycle, each processed in the following cycle.
            if (it_cnt_reg != '0) begin
                it_cnt_reg    <= it_cnt_reg - HW'(1);
                it_addr_reg   <= it_inc_reg ? (it_addr_reg + HW'(1))
                                            : (it_addr_reg - HW'(1));
                pend_reg      <= 1'b1;
                pend_addr_reg <= it_addr_reg;
            end else begin
                pend_reg <= 1'b0;
            end

            if (pend_reg && !it_move_reg) begin
                if (it_stats_reg) begin
                    tot_reg <= tot_reg + e_cnt;
                    if (e_cnt > lg_reg) begin
                        lg_reg <= e_cnt;
                    end
                end else if (act_reg == prbfa_pkg::ACT_ALLOC) begin
                    if (e_cnt >= need_reg && (!found_reg || e_cnt < best_cnt_reg)) begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= pend_addr_reg[IW-1:0];
                        best_first_reg <= e_first;
                        best_cnt_reg   <= e_cnt;
                    end
                end else begin
                    if (e_first < fp_reg) begin
                        hp_reg         <= 1'b1;
                        prev_first_reg <= e_first;
                        prev_cnt_reg   <= e_cnt;
                        ins_reg        <= pend_addr_reg + HW'(1);
                    end else if (!hn_reg) begin
                        hn_reg         <= 1'b1;
                        next_first_reg <= e_first;
                        next_cnt_reg   <= e_cnt;
                    end
                end
            end

            if (cmd.scan_start) begin
                it_cnt_reg   <= held_reg;
                it_addr_reg  <= '0;
                it_inc_reg   <= 1'b1;
                it_move_reg  <= 1'b0;
                it_stats_reg <= 1'b0;
                found_reg    <= 1'b0;
                hp_reg       <= 1'b0;
                hn_reg       <= 1'b0;
                ins_reg      <= '0;
            end

            if (cmd.stats_start) begin
                it_cnt_reg   <= held_reg;
                it_addr_reg  <= '0;
                it_inc_reg   <= 1'b1;
                it_move_reg  <= 1'b0;
                it_stats_reg <= 1'b1;
                tot_reg      <= '0;
                lg_reg       <= '0;
            end

            // Update plan: an optional shift through the iterator, then an
            // optional single entry write.
            if (cmd.decide) begin
                wr_req_reg  <= 1'b0;
                it_move_reg <= 1'b1;
                it_cnt_reg  <= '0;
                if (act_reg == prbfa_pkg::ACT_ALLOC) begin
                    if (!found_reg) begin
                        status_reg <= prbfa_pkg::STS_NO_FIT;
                    end else begin
                        grant_reg   <= OW'(64'(best_first_reg) << PAGE_SHIFT);
                        granted_reg <= SW'(64'(need_reg) << PAGE_SHIFT);
                        if (best_cnt_reg == need_reg) begin
                            // The run empties: close the gap above it.
                            it_addr_reg <= HW'(best_idx_reg) + HW'(1);
                            it_cnt_reg  <= held_reg - HW'(1) - HW'(best_idx_reg);
                            it_inc_reg  <= 1'b1;
                            held_reg    <= held_reg - HW'(1);
                        end else begin
                            wr_req_reg  <= 1'b1;
                            wr_addr_reg <= best_idx_reg;
                            wr_data_reg <= {PGW'(best_first_reg + PGW'(need_reg)),
                                            best_cnt_reg - need_reg};
                        end
                    end
                end else begin
                    if (ov_p) begin
                        status_reg <= prbfa_pkg::STS_OVERLAP_PREV;
                    end else if (ov_n) begin
                        status_reg <= prbfa_pkg::STS_OVERLAP_NEXT;
                    end else if (jp && jn) begin
                        wr_req_reg  <= 1'b1;
                        wr_addr_reg <= ins_m1;
                        wr_data_reg <= {prev_first_reg,
                                        prev_cnt_reg + need_reg + next_cnt_reg};
                        it_addr_reg <= ins_reg + HW'(1);
                        it_cnt_reg  <= held_reg - HW'(1) - ins_reg;
                        it_inc_reg  <= 1'b1;
                        held_reg    <= held_reg - HW'(1);
                    end else if (jp) begin
                        wr_req_reg  <= 1'b1;
                        wr_addr_reg <= ins_m1;
                        wr_data_reg <= {prev_first_reg, prev_cnt_reg + need_reg};
                    end else if (jn) begin
                        wr_req_reg  <= 1'b1;
                        wr_addr_reg <= ins_idx;
                        wr_data_reg <= {fp_reg, next_cnt_reg + need_reg};
                    end else if (held_reg == HW'(MAX_RUNS)) begin
                        status_reg <= prbfa_pkg::STS_TABLE_FULL;
                    end else begin
                        // Open a slot at the insert point, then fill it.
                        wr_req_reg  <= 1'b1;
                        wr_addr_reg <= ins_idx;
                        wr_data_reg <= {fp_reg, need_reg};
                        it_addr_reg <= held_reg - HW'(1);
                        it_cnt_reg  <= held_reg - ins_reg;
                        it_inc_reg  <= 1'b0;
                        held_reg    <= held_reg + HW'(1);
                    end
                end
            end

            if (cmd.finish) begin
                m_valid_reg   <= 1'b1;
                m_status_reg  <= status_reg;
                m_grant_reg   <= grant_reg;
                m_granted_reg <= granted_reg;
                m_tot_reg     <= prbfa_pkg::COUNT_W'(tot_reg);
                m_lg_reg      <= prbfa_pkg::COUNT_W'(lg_reg);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.chk_fail  = (chk_status != prbfa_pkg::STS_OK);
    assign sts.iter_done = (it_cnt_reg == '0) && !pend_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_grant_offset     = m_grant_reg;
    assign m_granted_bytes    = m_granted_reg;
    assign m_free_pages_total = m_tot_reg;
    assign m_largest_free_run = m_lg_reg;

endmodule
